// ----- rtl/core/rqs_pkg.sv -----
package rqs_pkg;

   // Command codes carried in the cmd field of a request beat.
   localparam logic [2:0] CMD_NEW_TASK = 3'd0;
   localparam logic [2:0] CMD_WAKE     = 3'd1;
   localparam logic [2:0] CMD_TICK     = 3'd2;
   localparam logic [2:0] CMD_SCHEDULE = 3'd3;
   localparam logic [2:0] CMD_YIELD    = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_BASE_SLICE   = 2'd0;
   localparam logic [1:0] REG_MIN_SLICE    = 2'd1;
   localparam logic [1:0] REG_MAX_SLICE    = 2'd2;
   localparam logic [1:0] REG_DEFAULT_PRIO = 2'd3;

   // Bit positions inside the per-task flag word.
   localparam int FL_QUEUED  = 0;
   localparam int FL_ARRAY   = 1;
   localparam int FL_RUN     = 2;
   localparam int FL_RESCHED = 3;

   typedef struct packed {
      logic [2:0] cmd;
      logic [3:0] task_id;
      logic [7:0] priority_req;
      logic       current_blocks;
   } req_type;

   typedef struct packed {
      logic [3:0]  running_task;
      logic        running_idle;
      logic        switched;
      logic        resched_pending;
      logic        woke;
      logic [15:0] slice_left;
   } rsp_type;

   typedef struct packed {
      logic [15:0] base_slice;
      logic [15:0] min_slice;
      logic [15:0] max_slice;
      logic [7:0]  default_priority;
   } cfg_type;

endpackage

// ----- rtl/core/priority_run_queue_scheduler.sv -----
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   req_data (cmd, task_id, priority_req, blocks)
// rsp      out        rsp_valid / rsp_stall   rsp_data (status after the command)
// csr      in/out     psel, penable, pready   paddr, pwdata, prdata
//
// One command is handled at a time by a small sequencer that walks the task
// tables and the head/tail memory one access step per cycle. A command runs its
// list work and the output step; a schedule or yield also scans the bitmap,
// eight priority levels per step and over both arrays if need be, and then
// picks the head of the first non-empty level.
// Reset is synchronous; it empties both arrays, clears all task flags and
// makes the idle task current. The next command is taken while a result waits
// in the output register; the sequencer holds at its last step while rsp is stalled.
module priority_run_queue_scheduler #(
   parameter int NUM_TASKS = 16,
   parameter int NUM_PRIOS = 140,
   parameter int RT_LIMIT  = 100
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rqs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rqs_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import rqs_pkg::*;

   localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int LW = $clog2(NUM_PRIOS);
   localparam int QD = 2 * NUM_PRIOS;
   localparam int QW = $clog2(QD);
   localparam int NC = (NUM_PRIOS + 7) / 8;
   localparam int MW = NC * 8;
   localparam int CW = (NC > 1) ? $clog2(NC) : 1;

   // Sequencer steps.
   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_D0   = 5'd1;
   localparam logic [4:0] ST_D1   = 5'd2;
   localparam logic [4:0] ST_D2   = 5'd3;
   localparam logic [4:0] ST_D3   = 5'd4;
   localparam logic [4:0] ST_E0   = 5'd5;
   localparam logic [4:0] ST_E1   = 5'd6;
   localparam logic [4:0] ST_E2   = 5'd7;
   localparam logic [4:0] ST_S0   = 5'd8;
   localparam logic [4:0] ST_N1   = 5'd9;
   localparam logic [4:0] ST_W0   = 5'd10;
   localparam logic [4:0] ST_W1   = 5'd11;
   localparam logic [4:0] ST_T0   = 5'd12;
   localparam logic [4:0] ST_T1   = 5'd13;
   localparam logic [4:0] ST_K0   = 5'd14;
   localparam logic [4:0] ST_Y0   = 5'd15;
   localparam logic [4:0] ST_P0   = 5'd16;
   localparam logic [4:0] ST_P1   = 5'd17;
   localparam logic [4:0] ST_F0   = 5'd18;
   localparam logic [4:0] ST_OUT  = 5'd19;

   cfg_type cfg;

   rqs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Per-task tables. Links have no reset; they are read only while the
   // bitmap and the queued flag say they hold a task.
   logic [7:0]    prio_ff  [NUM_TASKS];
   logic [15:0]   slice_ff [NUM_TASKS];
   logic [3:0]    flags_ff [NUM_TASKS];
   logic [TW-1:0] next_ff  [NUM_TASKS];
   logic [TW-1:0] prev_ff  [NUM_TASKS];

   logic [1:0][MW-1:0] map_ff;

   logic [4:0]    st_ff, d_ret_ff, e_ret_ff, s_ret_ff;
   logic [2:0]    cmd_ff;
   logic [7:0]    pr_ff, pt_ff;
   logic [TW-1:0] t_ff, nx_ff, pv_ff, cur_ff;
   logic          cur_idle_ff, idle_resched_ff, act_ff, e_arr_ff, arr_ff;
   logic [LW-1:0] lv_ff;
   logic [QW-1:0] q_ff;
   logic [CW-1:0] chunk_ff;
   logic          tried_ff, fnd_ff, woke_ff, sw_ff, qd_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   // Head/tail memory port signals.
   logic [QW-1:0] q_rd;
   logic          head_we, tail_we;
   logic [TW-1:0] head_wd, tail_wd, head_rd, tail_rd;

   rqs_qmem #(.DEPTH(QD), .AW(QW), .DW(TW)) u_qmem (
      .clock   (clock),
      .rd_addr (q_rd),
      .wr_addr (q_ff),
      .head_we (head_we),
      .head_wd (head_wd),
      .tail_we (tail_we),
      .tail_wd (tail_wd),
      .head_rd (head_rd),
      .tail_rd (tail_rd)
   );

   logic          accept;
   logic          tid_ok;
   logic [TW-1:0] tid;
   logic [7:0]    t_prio;
   logic [LW-1:0] t_lv;
   logic [QW-1:0] q_calc;
   logic          q_arr;
   logic [7:0]    chunk_bits;
   logic [2:0]    chunk_pe;
   logic [LW-1:0] scan_lv;
   logic [QW-1:0] scan_q;
   logic signed [17:0] s_raw;
   logic [15:0]   slice_new;
   logic [15:0]   slice_dec;
   logic          changed;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign tid_ok    = (32'(req_data.task_id) < NUM_TASKS);
   assign tid       = TW'(req_data.task_id);

   // Queue level of the operand task: priorities past the last level share it.
   assign t_prio = prio_ff[t_ff];
   assign t_lv   = ({1'b0, t_prio} >= 9'(NUM_PRIOS)) ? LW'(NUM_PRIOS - 1) : LW'(t_prio);
   assign q_arr  = (st_ff == ST_D0) ? flags_ff[t_ff][FL_ARRAY] : e_arr_ff;
   assign q_calc = q_arr ? QW'(NUM_PRIOS) + QW'(t_lv) : QW'(t_lv);

   // Bitmap scan, eight levels per cycle, lowest level wins.
   assign chunk_bits = map_ff[act_ff][{chunk_ff, 3'b000} +: 8];
   always_comb begin
      chunk_pe = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (chunk_bits[i]) begin
            chunk_pe = 3'(i);
         end
      end
   end
   assign scan_lv = LW'({chunk_ff, chunk_pe});
   assign scan_q  = act_ff ? QW'(NUM_PRIOS) + QW'(scan_lv) : QW'(scan_lv);

   assign q_rd = (st_ff == ST_P0) ? scan_q : q_calc;

   // Time slice from the current priority of the operand task. Real-time
   // priorities get the upper clamp; otherwise the signed nice offset is
   // taken from the base slice and clamped, the upper clamp winning.
   assign s_raw = $signed({2'b00, cfg.base_slice})
                - ($signed({10'd0, t_prio}) - $signed({10'd0, cfg.default_priority}));
   always_comb begin
      if (32'(t_prio) < RT_LIMIT) begin
         slice_new = cfg.max_slice;
      end else if (s_raw > $signed({2'b00, cfg.max_slice})) begin
         slice_new = cfg.max_slice;
      end else if (s_raw < $signed({2'b00, cfg.min_slice})) begin
         slice_new = (cfg.min_slice > cfg.max_slice) ? cfg.max_slice : cfg.min_slice;
      end else begin
         slice_new = s_raw[15:0];
      end
   end

   assign slice_dec = (slice_ff[t_ff] != 16'd0) ? slice_ff[t_ff] - 16'd1 : 16'd0;
   assign changed   = (fnd_ff == cur_idle_ff) || (fnd_ff && (nx_ff != cur_ff));

   // Memory writes: unlink updates in D1, link-in writes in E1.
   always_comb begin
      head_we = 1'b0;
      tail_we = 1'b0;
      head_wd = t_ff;
      tail_wd = t_ff;
      if (st_ff == ST_D1) begin
         if (head_rd == t_ff && tail_rd != t_ff) begin
            head_we = 1'b1;
            head_wd = nx_ff;
         end else if (head_rd != t_ff && tail_rd == t_ff) begin
            tail_we = 1'b1;
            tail_wd = pv_ff;
         end
      end else if (st_ff == ST_E1) begin
         tail_we = 1'b1;
         head_we = !map_ff[arr_ff][lv_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff           <= ST_IDLE;
         cur_idle_ff     <= 1'b1;
         cur_ff          <= '0;
         idle_resched_ff <= 1'b0;
         act_ff          <= 1'b0;
         map_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            prio_ff[i]  <= 8'd0;
            slice_ff[i] <= 16'd0;
            flags_ff[i] <= 4'd0;
         end
      end else begin
         // The output step reloads the result register itself.
         if (rsp_valid_ff && !rsp_stall && st_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (st_ff)
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff   <= req_data.cmd;
                  pr_ff    <= req_data.priority_req;
                  woke_ff  <= 1'b0;
                  sw_ff    <= 1'b0;
                  chunk_ff <= '0;
                  tried_ff <= 1'b0;
                  e_ret_ff <= ST_OUT;
                  e_arr_ff <= act_ff;
                  case (req_data.cmd)
                     CMD_NEW_TASK: begin
                        t_ff     <= tid;
                        d_ret_ff <= ST_N1;
                        st_ff    <= tid_ok ? ST_D0 : ST_OUT;
                     end
                     CMD_WAKE: begin
                        t_ff  <= tid;
                        st_ff <= tid_ok ? ST_W0 : ST_OUT;
                     end
                     CMD_TICK: begin
                        t_ff  <= cur_ff;
                        st_ff <= cur_idle_ff ? ST_OUT : ST_T0;
                     end
                     CMD_SCHEDULE: begin
                        t_ff  <= cur_ff;
                        st_ff <= (req_data.current_blocks && !cur_idle_ff) ? ST_K0 : ST_P0;
                     end
                     CMD_YIELD: begin
                        t_ff  <= cur_ff;
                        st_ff <= ST_Y0;
                     end
                     default: st_ff <= ST_OUT;
                  endcase
               end
            end
            // Unlink the operand task from the FIFO that holds it.
            ST_D0: begin
               if (!flags_ff[t_ff][FL_QUEUED]) begin
                  st_ff <= d_ret_ff;
               end else begin
                  flags_ff[t_ff][FL_QUEUED] <= 1'b0;
                  arr_ff <= flags_ff[t_ff][FL_ARRAY];
                  lv_ff  <= t_lv;
                  q_ff   <= q_calc;
                  nx_ff  <= next_ff[t_ff];
                  pv_ff  <= prev_ff[t_ff];
                  st_ff  <= ST_D1;
               end
            end
            ST_D1: begin
               if (head_rd == t_ff && tail_rd == t_ff) begin
                  map_ff[arr_ff][lv_ff] <= 1'b0;
                  st_ff <= d_ret_ff;
               end else if (head_rd == t_ff || tail_rd == t_ff) begin
                  st_ff <= d_ret_ff;
               end else begin
                  st_ff <= ST_D2;
               end
            end
            ST_D2: begin
               next_ff[pv_ff] <= nx_ff;
               st_ff <= ST_D3;
            end
            ST_D3: begin
               prev_ff[nx_ff] <= pv_ff;
               st_ff <= d_ret_ff;
            end
            // Append the operand task at the tail of its level in array e_arr.
            ST_E0: begin
               flags_ff[t_ff][FL_QUEUED] <= 1'b1;
               flags_ff[t_ff][FL_ARRAY]  <= e_arr_ff;
               arr_ff <= e_arr_ff;
               lv_ff  <= t_lv;
               q_ff   <= q_calc;
               st_ff  <= ST_E1;
            end
            ST_E1: begin
               if (map_ff[arr_ff][lv_ff]) begin
                  next_ff[tail_rd] <= t_ff;
                  pv_ff <= tail_rd;
                  st_ff <= ST_E2;
               end else begin
                  map_ff[arr_ff][lv_ff] <= 1'b1;
                  st_ff <= e_ret_ff;
               end
            end
            ST_E2: begin
               prev_ff[t_ff] <= pv_ff;
               st_ff <= e_ret_ff;
            end
            ST_S0: begin
               slice_ff[t_ff] <= slice_new;
               st_ff <= s_ret_ff;
            end
            ST_N1: begin
               prio_ff[t_ff] <= pr_ff;
               flags_ff[t_ff][FL_RUN] <= 1'b1;
               s_ret_ff <= ST_E0;
               st_ff    <= ST_S0;
            end
            ST_W0: begin
               if (flags_ff[t_ff][FL_RUN]) begin
                  st_ff <= ST_OUT;
               end else begin
                  woke_ff <= 1'b1;
                  flags_ff[t_ff][FL_RUN] <= 1'b1;
                  qd_ff <= flags_ff[t_ff][FL_QUEUED];
                  pt_ff <= t_prio;
                  if (cur_idle_ff) begin
                     idle_resched_ff <= 1'b1;
                     st_ff <= flags_ff[t_ff][FL_QUEUED] ? ST_OUT : ST_E0;
                  end else begin
                     st_ff <= ST_W1;
                  end
               end
            end
            ST_W1: begin
               if (pt_ff < prio_ff[cur_ff]) begin
                  flags_ff[cur_ff][FL_RESCHED] <= 1'b1;
               end
               st_ff <= qd_ff ? ST_OUT : ST_E0;
            end
            ST_T0: begin
               if (slice_dec != 16'd0) begin
                  slice_ff[t_ff] <= slice_dec;
                  st_ff <= ST_OUT;
               end else begin
                  flags_ff[t_ff][FL_RESCHED] <= 1'b1;
                  s_ret_ff <= ST_T1;
                  st_ff    <= ST_S0;
               end
            end
            ST_T1: begin
               e_arr_ff <= !act_ff;
               d_ret_ff <= ST_E0;
               st_ff    <= flags_ff[t_ff][FL_QUEUED] ? ST_D0 : ST_OUT;
            end
            ST_K0: begin
               flags_ff[t_ff][FL_RUN] <= 1'b0;
               d_ret_ff <= ST_P0;
               st_ff    <= ST_D0;
            end
            ST_Y0: begin
               e_ret_ff <= ST_P0;
               d_ret_ff <= ST_E0;
               if (!cur_idle_ff && flags_ff[t_ff][FL_RUN] && flags_ff[t_ff][FL_QUEUED]) begin
                  st_ff <= ST_D0;
               end else begin
                  st_ff <= ST_P0;
               end
            end
            // Scan the active bitmap; when it is empty the arrays swap once.
            ST_P0: begin
               if (chunk_bits != 8'd0) begin
                  st_ff <= ST_P1;
               end else if (32'(chunk_ff) == NC - 1) begin
                  chunk_ff <= '0;
                  if (tried_ff) begin
                     fnd_ff <= 1'b0;
                     st_ff  <= ST_F0;
                  end else begin
                     act_ff   <= !act_ff;
                     tried_ff <= 1'b1;
                  end
               end else begin
                  chunk_ff <= chunk_ff + CW'(1);
               end
            end
            ST_P1: begin
               nx_ff  <= head_rd;
               fnd_ff <= 1'b1;
               st_ff  <= ST_F0;
            end
            ST_F0: begin
               if (cur_idle_ff) begin
                  idle_resched_ff <= 1'b0;
               end else begin
                  flags_ff[cur_ff][FL_RESCHED] <= 1'b0;
               end
               if (changed) begin
                  cur_idle_ff <= !fnd_ff;
                  cur_ff      <= fnd_ff ? nx_ff : '0;
                  sw_ff       <= 1'b1;
               end
               st_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_ff.running_task    <= cur_idle_ff ? 4'd0 : 4'(cur_ff);
                  rsp_ff.running_idle    <= cur_idle_ff;
                  rsp_ff.switched        <= sw_ff;
                  rsp_ff.resched_pending <= cur_idle_ff ? idle_resched_ff
                                                        : flags_ff[cur_ff][FL_RESCHED];
                  rsp_ff.woke            <= woke_ff;
                  rsp_ff.slice_left      <= cur_idle_ff ? 16'd0 : slice_ff[cur_ff];
                  st_ff                  <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_idle_reports_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.running_idle || rsp_data.running_task == 4'd0))
      else $error("idle result carries a task number");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (st_ff != ST_IDLE))
      else $error("accepted command left the sequencer idle");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(st_ff) == ST_OUT))
      else $error("result raised outside the output step");

   a_switch_only_on_pick: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_OUT && sw_ff) |-> (cmd_ff == CMD_SCHEDULE || cmd_ff == CMD_YIELD))
      else $error("switch flagged by a command that does not schedule");
`endif

endmodule

// ----- rtl/core/rqs_csr.sv -----
module rqs_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [3:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready,
   output rqs_pkg::cfg_type cfg
);
   import rqs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_BASE_SLICE:   cfg_in.base_slice       = pwdata[15:0];
            REG_MIN_SLICE:    cfg_in.min_slice        = pwdata[15:0];
            REG_MAX_SLICE:    cfg_in.max_slice        = pwdata[15:0];
            REG_DEFAULT_PRIO: cfg_in.default_priority = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_BASE_SLICE:   prdata = {16'd0, cfg_ff.base_slice};
         REG_MIN_SLICE:    prdata = {16'd0, cfg_ff.min_slice};
         REG_MAX_SLICE:    prdata = {16'd0, cfg_ff.max_slice};
         REG_DEFAULT_PRIO: prdata = {24'd0, cfg_ff.default_priority};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_slice       <= 16'd100;
         cfg_ff.min_slice        <= 16'd5;
         cfg_ff.max_slice        <= 16'd200;
         cfg_ff.default_priority <= 8'd120;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/rqs_qmem.sv -----
module rqs_qmem #(
   parameter int DEPTH = 280,
   parameter int AW    = 9,
   parameter int DW    = 4
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   input  logic [AW-1:0] wr_addr,
   input  logic          head_we,
   input  logic [DW-1:0] head_wd,
   input  logic          tail_we,
   input  logic [DW-1:0] tail_wd,
   output logic [DW-1:0] head_rd,
   output logic [DW-1:0] tail_rd
);

   // Head and tail of every priority FIFO of both arrays.
   logic [DW-1:0] head_mem [DEPTH];
   logic [DW-1:0] tail_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[wr_addr] <= head_wd;
      end
      if (tail_we) begin
         tail_mem[wr_addr] <= tail_wd;
      end
      head_rd <= head_mem[rd_addr];
      tail_rd <= tail_mem[rd_addr];
   end

endmodule

// ----- test/rqs_checker.sv -----
`timescale 1ns / 1ps

module rqs_checker
   import rqs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   input  logic    csr_psel,
   input  logic    csr_penable,
   input  logic    csr_pwrite,
   input  logic    csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int      fail_count,
   output int      pending
);

   localparam int NT      = 16;
   localparam int NP      = 140;
   localparam int RT_PRIO = 100;

   typedef logic [3:0] tid_type;

   logic [7:0]    t_prio  [NT];
   logic [15:0]   t_slice [NT];
   logic [3:0]    t_flags [NT];
   tid_type       nxt     [NT];
   tid_type       prv     [NT];
   tid_type       qhead   [2*NP];
   tid_type       qtail   [2*NP];
   logic [NP-1:0] busy_map [2];
   logic          act;
   logic          cur_idle;
   tid_type       cur_id;
   logic          idle_rs;
   logic [15:0]   base_sl, min_sl, max_sl;
   logic [7:0]    dflt_prio;

   rsp_type status_q[$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic int level_of(tid_type t);
      return (t_prio[t] >= NP) ? NP - 1 : int'(t_prio[t]);
   endfunction

   // Slice arithmetic is signed so that a large priority offset clamps cleanly.
   function automatic logic [15:0] slice_for(tid_type t);
      int p, s;
      p = int'(t_prio[t]);
      if (p < RT_PRIO) return max_sl;
      s = int'(base_sl) - (p - int'(dflt_prio));
      if (s < int'(min_sl)) s = int'(min_sl);
      if (s > int'(max_sl)) s = int'(max_sl);
      return s[15:0];
   endfunction

   function automatic void enqueue(tid_type t, logic a);
      int lv, q;
      lv = level_of(t);
      q = int'(a) * NP + lv;
      if (busy_map[a][lv]) begin
         nxt[qtail[q]] = t;
         prv[t] = qtail[q];
      end else begin
         qhead[q] = t;
         busy_map[a][lv] = 1'b1;
      end
      qtail[q] = t;
      t_flags[t][FL_QUEUED] = 1'b1;
      t_flags[t][FL_ARRAY] = a;
   endfunction

   function automatic void dequeue(tid_type t);
      int lv, q;
      logic a, h, e;
      if (!t_flags[t][FL_QUEUED]) return;
      a = t_flags[t][FL_ARRAY];
      lv = level_of(t);
      q = int'(a) * NP + lv;
      h = (qhead[q] == t);
      e = (qtail[q] == t);
      if (h && e) busy_map[a][lv] = 1'b0;
      else if (h) qhead[q] = nxt[t];
      else if (e) qtail[q] = prv[t];
      else begin
         nxt[prv[t]] = nxt[t];
         prv[nxt[t]] = prv[t];
      end
      t_flags[t][FL_QUEUED] = 1'b0;
   endfunction

   // Swaps the arrays when the active one is empty, then takes the head of
   // the most urgent non-empty level.
   function automatic logic pick_next(output tid_type pick);
      pick = '0;
      if (busy_map[act] == '0) act = ~act;
      for (int lv = 0; lv < NP; lv++) begin
         if (busy_map[act][lv]) begin
            pick = qhead[int'(act) * NP + lv];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic do_schedule(logic blocks);
      tid_type nx;
      logic found;
      if (blocks && !cur_idle) begin
         t_flags[cur_id][FL_RUN] = 1'b0;
         dequeue(cur_id);
      end
      found = pick_next(nx);
      if (cur_idle) idle_rs = 1'b0;
      else t_flags[cur_id][FL_RESCHED] = 1'b0;
      if (found != !cur_idle || (found && nx != cur_id)) begin
         cur_idle = !found;
         cur_id = found ? nx : '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type run_command(req_type r);
      rsp_type o;
      logic sw, woke;
      tid_type t;
      sw = 1'b0;
      woke = 1'b0;
      t = r.task_id;
      case (r.cmd)
         CMD_NEW_TASK: begin
            dequeue(t);
            t_prio[t] = r.priority_req;
            t_slice[t] = slice_for(t);
            t_flags[t][FL_RUN] = 1'b1;
            enqueue(t, act);
         end
         CMD_WAKE: begin
            if (!t_flags[t][FL_RUN]) begin
               woke = 1'b1;
               t_flags[t][FL_RUN] = 1'b1;
               if (!t_flags[t][FL_QUEUED]) enqueue(t, act);
               // The idle task ranks below every real task.
               if (cur_idle) idle_rs = 1'b1;
               else if (t_prio[t] < t_prio[cur_id]) t_flags[cur_id][FL_RESCHED] = 1'b1;
            end
         end
         CMD_TICK: begin
            if (!cur_idle) begin
               if (t_slice[cur_id] > 0) t_slice[cur_id] = t_slice[cur_id] - 1'b1;
               if (t_slice[cur_id] == 0) begin
                  t_slice[cur_id] = slice_for(cur_id);
                  if (t_flags[cur_id][FL_QUEUED]) begin
                     dequeue(cur_id);
                     enqueue(cur_id, ~act);
                  end
                  t_flags[cur_id][FL_RESCHED] = 1'b1;
               end
            end
         end
         CMD_SCHEDULE: sw = do_schedule(r.current_blocks);
         CMD_YIELD: begin
            if (!cur_idle && t_flags[cur_id][FL_RUN] && t_flags[cur_id][FL_QUEUED]) begin
               dequeue(cur_id);
               enqueue(cur_id, act);
            end
            sw = do_schedule(1'b0);
         end
         default: ;
      endcase
      o.running_task    = cur_idle ? '0 : cur_id;
      o.running_idle    = cur_idle;
      o.switched        = sw;
      o.resched_pending = cur_idle ? idle_rs : t_flags[cur_id][FL_RESCHED];
      o.woke            = woke;
      o.slice_left      = cur_idle ? '0 : t_slice[cur_id];
      return o;
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      $display("%0t: rsp mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NT; i++) begin
            t_prio[i] = '0;
            t_slice[i] = '0;
            t_flags[i] = '0;
         end
         busy_map[0] = '0;
         busy_map[1] = '0;
         act = 1'b0;
         cur_idle = 1'b1;
         cur_id = '0;
         idle_rs = 1'b0;
         base_sl = 16'd100;
         min_sl = 16'd5;
         max_sl = 16'd200;
         dflt_prio = 8'd120;
         status_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_q.size() == 0) begin
               report_mismatch("unexpected beat, queue depth", 0, 1);
            end else begin
               want = status_q.pop_front();
               if (rsp_data.running_task !== want.running_task)
                  report_mismatch("running_task", want.running_task, rsp_data.running_task);
               if (rsp_data.running_idle !== want.running_idle)
                  report_mismatch("running_idle", want.running_idle, rsp_data.running_idle);
               if (rsp_data.switched !== want.switched)
                  report_mismatch("switched", want.switched, rsp_data.switched);
               if (rsp_data.resched_pending !== want.resched_pending)
                  report_mismatch("resched_pending", want.resched_pending,
                                  rsp_data.resched_pending);
               if (rsp_data.woke !== want.woke)
                  report_mismatch("woke", want.woke, rsp_data.woke);
               if (rsp_data.slice_left !== want.slice_left)
                  report_mismatch("slice_left", want.slice_left, rsp_data.slice_left);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_BASE_SLICE:   base_sl = csr_pwdata[15:0];
               REG_MIN_SLICE:    min_sl = csr_pwdata[15:0];
               REG_MAX_SLICE:    max_sl = csr_pwdata[15:0];
               REG_DEFAULT_PRIO: dflt_prio = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) status_q.push_back(run_command(req_data));
      end
      pending <= status_q.size();
   end

endmodule

// ----- test/priority_run_queue_scheduler_tb.sv -----
`timescale 1ns / 1ps

module priority_run_queue_scheduler_tb;
   import rqs_pkg::*;

   // A stall of this many cycles with no beat on any port means the block hung.
   localparam int WATCHDOG_LIMIT = 5000;
   // Items per configuration phase in the random part.
   localparam int PHASE_ITEMS = 90;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending;
   int send_idle_pct = 20;
   int recv_stall_pct = 64;
   int quiet_cycles = 0;

   priority_run_queue_scheduler u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   rqs_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .fail_count, .pending
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random, one decision per cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Counts cycles in which no beat moves on any port.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one command beat. Acceptance is judged from the stall seen at the
   // falling edge, which is settled and is what the next rising edge samples.
   task automatic send_cmd(logic [2:0] cmd, logic [3:0] id, logic [7:0] prio, logic blk);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{cmd: cmd, task_id: id, priority_req: prio, current_blocks: blk};
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   // Holds the sender back until every expected status beat has come out.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register is written at the edge that
   // ends the access cycle.
   task automatic csr_write(logic [1:0] idx, logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic load_slices(logic [15:0] base, logic [15:0] lo, logic [15:0] hi,
                              logic [7:0] dflt);
      drain_results();
      csr_write(REG_BASE_SLICE, base);
      csr_write(REG_MIN_SLICE, lo);
      csr_write(REG_MAX_SLICE, hi);
      csr_write(REG_DEFAULT_PRIO, {8'd0, dflt});
   endtask

   // Random command mix: mostly task creation, wakes, ticks and schedules so
   // that the queues fill and drain, with a few unknown codes as noise.
   task automatic send_random_cmd();
      int roll;
      logic [2:0] cmd;
      logic [7:0] prio;
      roll = $urandom_range(99);
      if (roll < 15) cmd = CMD_NEW_TASK;
      else if (roll < 33) cmd = CMD_WAKE;
      else if (roll < 63) cmd = CMD_TICK;
      else if (roll < 85) cmd = CMD_SCHEDULE;
      else if (roll < 95) cmd = CMD_YIELD;
      else cmd = 3'($urandom_range(5, 7));
      roll = $urandom_range(9);
      if (roll < 3) prio = 8'($urandom_range(0, 99));
      else if (roll < 8) prio = 8'($urandom_range(100, 139));
      else prio = 8'($urandom_range(0, 255));
      send_cmd(cmd, 4'($urandom_range(15)), prio, 1'($urandom_range(2) == 0));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset register values.
      send_cmd(CMD_SCHEDULE, 4'd0, 8'd0, 1'b1);     // idle cannot block
      send_cmd(CMD_TICK, 4'd0, 8'd0, 1'b0);         // tick while idle
      send_cmd(CMD_YIELD, 4'd0, 8'd0, 1'b0);        // yield with nothing queued
      send_cmd(CMD_WAKE, 4'd3, 8'd0, 1'b0);         // wake while idle
      send_cmd(CMD_NEW_TASK, 4'd0, 8'd0, 1'b0);
      send_cmd(CMD_NEW_TASK, 4'd15, 8'd255, 1'b1);  // above the top level
      send_cmd(CMD_NEW_TASK, 4'd5, 8'd139, 1'b0);
      send_cmd(CMD_NEW_TASK, 4'd7, 8'd140, 1'b0);
      send_cmd(CMD_NEW_TASK, 4'd9, 8'd99, 1'b0);    // last real-time level
      send_cmd(CMD_SCHEDULE, 4'd0, 8'd0, 1'b0);
      send_cmd(CMD_TICK, 4'd0, 8'd0, 1'b0);
      send_cmd(CMD_WAKE, 4'd5, 8'd0, 1'b0);         // already runnable
      send_cmd(CMD_YIELD, 4'd0, 8'd0, 1'b0);
      send_cmd(CMD_SCHEDULE, 4'd0, 8'd0, 1'b1);     // current task blocks
      send_cmd(CMD_NEW_TASK, 4'd5, 8'd100, 1'b0);   // recreate a queued task
      send_cmd(CMD_WAKE, 4'd0, 8'd0, 1'b0);         // wake beats the current task
      send_cmd(3'd5, 4'd10, 8'd170, 1'b1);
      send_cmd(3'd7, 4'd15, 8'd255, 1'b1);
      send_cmd(CMD_SCHEDULE, 4'd0, 8'd0, 1'b0);
      send_cmd(CMD_SCHEDULE, 4'd0, 8'd0, 1'b1);
      send_cmd(CMD_SCHEDULE, 4'd0, 8'd0, 1'b1);
      send_cmd(CMD_SCHEDULE, 4'd0, 8'd0, 1'b1);
      send_cmd(CMD_SCHEDULE, 4'd0, 8'd0, 1'b1);

      // Random part, one register setting per phase. Short slices make ticks
      // expire tasks into the expired array and force array swaps.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: load_slices(16'd3, 16'd1, 16'd4, 8'd120);
            1: load_slices(16'd65535, 16'd65535, 16'd65535, 8'd0);
            2: load_slices(16'd1, 16'd1, 16'd1, 8'd139);
            3: load_slices(16'd6, 16'd300, 16'd2, 8'd60);   // clamps cross
            default: load_slices(16'd100, 16'd5, 16'd200, 8'd120);
         endcase
         if (ph >= 2) begin
            send_idle_pct = 64;
            recv_stall_pct = 20;
         end
         if (ph == 4) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) send_random_cmd();
      end

      drain_results();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- priority_run_queue_scheduler.f -----
rtl/core/rqs_pkg.sv
rtl/core/rqs_csr.sv
rtl/core/rqs_qmem.sv
rtl/core/priority_run_queue_scheduler.sv
test/rqs_checker.sv
test/priority_run_queue_scheduler_tb.sv
